// File: design/udps_pkg.sv
// ----------------------------------------------------------------------------
// udps_pkg - shared types and codes of the pairing sequencer
// Event, action and state codes, config register indexes and the beat
// structs that travel between the sequencer modules.
// ----------------------------------------------------------------------------
package udps_pkg;

    localparam int unsigned MAX_RECOVERY_CYCLES_DEF = 3;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned TO_W    = 22;
    localparam int unsigned CMD_W   = 4;
    localparam int unsigned ACT_W   = 3;
    localparam int unsigned STATE_W = 4;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 22;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_RETRY_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENTIFY_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_READ_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_RETRY_TIME  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_FAIL_TIME   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE_TIMEOUT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_SPACING    = 3'd7;

    localparam logic [CNT_W-1:0] RETRY_MIN = 3'd1;
    localparam logic [CNT_W-1:0] RETRY_MAX = 3'd5;

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE      = 4'd0,
        ST_IDENTIFY  = 4'd1,
        ST_READ_KEY  = 4'd2,
        ST_CUT       = 4'd3,
        ST_WAIT_DROP = 4'd4,
        ST_DONE      = 4'd5,
        ST_TETHER    = 4'd6,
        ST_FOREIGN   = 4'd7,
        ST_SHARE     = 4'd8,
        ST_SHARE_UP  = 4'd9
    } udps_state_t;

    typedef enum logic [CMD_W-1:0] {
        EV_TICK          = 4'd0,
        EV_OK            = 4'd1,
        EV_FAIL          = 4'd2,
        EV_NOT_DONGLE    = 4'd3,
        EV_CONFLICT      = 4'd4,
        EV_LINK_UP       = 4'd5,
        EV_LINK_UP_OTHER = 4'd6,
        EV_LINK_DOWN     = 4'd7,
        EV_REPAIR        = 4'd8,
        EV_AP_STALE      = 4'd9
    } udps_ev_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE         = 3'd0,
        ACT_GET_INFO     = 3'd1,
        ACT_GET_KEY      = 3'd2,
        ACT_POST_CUT     = 3'd3,
        ACT_POWER_CYCLE  = 3'd4,
        ACT_GIVE_UP      = 3'd5,
        ACT_REBOOT       = 3'd6,
        ACT_ENSURE_SHARE = 3'd7
    } udps_act_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] now_ms;
        logic              set_reboot_pending;
    } udps_evt_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [STATE_W-1:0] state_code;
        logic               link_is_up;
    } udps_res_t;

    // retry limit is already clamped to 1..5 here
    typedef struct packed {
        logic             share_mode;
        logic [CNT_W-1:0] retry_lim;
        logic [TO_W-1:0]  identify_to;
        logic [TO_W-1:0]  key_read_to;
        logic [TO_W-1:0]  drop_retry;
        logic [TO_W-1:0]  drop_fail;
        logic [TO_W-1:0]  share_to;
        logic [TO_W-1:0]  spacing;
    } udps_cfg_t;

endpackage

// File: design/udps_evt_if.sv
// ----------------------------------------------------------------------------
// udps_evt_if - event channel
// Valid/ready channel that carries one event per beat.
// ----------------------------------------------------------------------------
interface udps_evt_if;
    logic                        valid;
    logic                        ready;
    logic [udps_pkg::CMD_W-1:0]  cmd;
    logic [udps_pkg::TIME_W-1:0] now_ms;
    logic                        set_reboot_pending;

    modport source (output valid, cmd, now_ms, set_reboot_pending, input ready);
    modport sink   (input valid, cmd, now_ms, set_reboot_pending, output ready);
endinterface

// File: design/udps_res_if.sv
// ----------------------------------------------------------------------------
// udps_res_if - result channel
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
interface udps_res_if;
    logic                         valid;
    logic                         ready;
    logic [udps_pkg::ACT_W-1:0]   action;
    logic [udps_pkg::STATE_W-1:0] state_code;
    logic                         link_is_up;

    modport source (output valid, action, state_code, link_is_up, input ready);
    modport sink   (input valid, action, state_code, link_is_up, output ready);
endinterface

// File: design/udps_cfg.sv
// ----------------------------------------------------------------------------
// udps_cfg - configuration registers
// Write-only register file; presents the retry limit clamped to 1..5.
// ----------------------------------------------------------------------------
module udps_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                we,
    input  logic [udps_pkg::CFG_IDX_W-1:0]      idx,
    input  logic [udps_pkg::CFG_DATA_W-1:0]     wdata,
    output udps_pkg::udps_cfg_t                 cfg
);

    logic                         share_mode_reg;
    logic [udps_pkg::CNT_W-1:0]   retry_reg;
    logic [udps_pkg::TO_W-1:0]    identify_to_reg;
    logic [udps_pkg::TO_W-1:0]    key_read_to_reg;
    logic [udps_pkg::TO_W-1:0]    drop_retry_reg;
    logic [udps_pkg::TO_W-1:0]    drop_fail_reg;
    logic [udps_pkg::TO_W-1:0]    share_to_reg;
    logic [udps_pkg::TO_W-1:0]    spacing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            share_mode_reg  <= 1'b0;
            retry_reg       <= 3'd3;
            identify_to_reg <= 22'd10000;
            key_read_to_reg <= 22'd10000;
            drop_retry_reg  <= 22'd3000;
            drop_fail_reg   <= 22'd10000;
            share_to_reg    <= 22'd10000;
            spacing_reg     <= 22'd60000;
        end
        else if (we)
        begin
            unique case (idx)
                udps_pkg::CFG_SHARE_MODE:       share_mode_reg  <= wdata[0];
                udps_pkg::CFG_CUT_RETRY_LIMIT:  retry_reg       <= wdata[udps_pkg::CNT_W-1:0];
                udps_pkg::CFG_IDENTIFY_TIMEOUT: identify_to_reg <= wdata;
                udps_pkg::CFG_KEY_READ_TIMEOUT: key_read_to_reg <= wdata;
                udps_pkg::CFG_DROP_RETRY_TIME:  drop_retry_reg  <= wdata;
                udps_pkg::CFG_DROP_FAIL_TIME:   drop_fail_reg   <= wdata;
                udps_pkg::CFG_SHARE_TIMEOUT:    share_to_reg    <= wdata;
                udps_pkg::CFG_CYCLE_SPACING:    spacing_reg     <= wdata;
                default:                        share_mode_reg  <= share_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.share_mode  = share_mode_reg;
        if (retry_reg < udps_pkg::RETRY_MIN)
            cfg.retry_lim = udps_pkg::RETRY_MIN;
        else if (retry_reg > udps_pkg::RETRY_MAX)
            cfg.retry_lim = udps_pkg::RETRY_MAX;
        else
            cfg.retry_lim = retry_reg;
        cfg.identify_to = identify_to_reg;
        cfg.key_read_to = key_read_to_reg;
        cfg.drop_retry  = drop_retry_reg;
        cfg.drop_fail   = drop_fail_reg;
        cfg.share_to    = share_to_reg;
        cfg.spacing     = spacing_reg;
    end

endmodule

// File: design/udps_fsm.sv
// ----------------------------------------------------------------------------
// udps_fsm - pairing state machine
// Holds the sequencer state and works out one event per step in a single
// pass; state updates on step, the result is combinational.
// ----------------------------------------------------------------------------
module udps_fsm #(
    parameter int unsigned MAX_RECOVERY_CYCLES = udps_pkg::MAX_RECOVERY_CYCLES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  udps_pkg::udps_evt_t  evt,
    input  udps_pkg::udps_cfg_t  cfg,
    output udps_pkg::udps_res_t  res
);

    localparam logic [udps_pkg::CNT_W-1:0] MAX_CYC = udps_pkg::CNT_W'(MAX_RECOVERY_CYCLES);

    udps_pkg::udps_state_t          st_reg, st_next;
    logic [udps_pkg::TIME_W-1:0]    entered_reg, entered_next;
    logic [udps_pkg::TIME_W-1:0]    last_at_reg, last_at_next;
    logic                           known_reg, known_next;
    logic [udps_pkg::CNT_W-1:0]     cyc_reg, cyc_next;
    logic [udps_pkg::CNT_W-1:0]     cut_reg, cut_next;
    logic                           link_reg, link_next;
    logic                           reboot_reg, reboot_next;

    udps_pkg::udps_act_t            act;
    logic [udps_pkg::TIME_W-1:0]    t_in_state;
    logic [udps_pkg::TIME_W-1:0]    t_since_cycle;
    logic                           rflag;
    logic                           do_rec;
    logic                           rec_give;
    logic                           is_repair;
    logic [udps_pkg::CNT_W-1:0]     rec_cyc;

    assign t_in_state    = evt.now_ms - entered_reg;
    assign t_since_cycle = evt.now_ms - last_at_reg;
    assign rflag         = reboot_reg | evt.set_reboot_pending;
    assign is_repair     = (evt.cmd == udps_pkg::EV_REPAIR);

    // repair clears the budget first, so it never gives up
    assign rec_cyc  = is_repair ? '0 : cyc_reg;
    assign rec_give = !is_repair &&
                      ((cyc_reg >= MAX_CYC) ||
                       (known_reg && (t_since_cycle < {10'd0, cfg.spacing})));

    always_comb
    begin
        st_next      = st_reg;
        entered_next = entered_reg;
        last_at_next = last_at_reg;
        known_next   = known_reg;
        cyc_next     = cyc_reg;
        cut_next     = cut_reg;
        link_next    = link_reg;
        reboot_next  = rflag;
        act          = udps_pkg::ACT_NONE;
        do_rec       = 1'b0;

        priority if (evt.cmd == udps_pkg::EV_LINK_DOWN)
        begin
            link_next = 1'b0;
            if (st_reg == udps_pkg::ST_WAIT_DROP || st_reg == udps_pkg::ST_CUT)
            begin
                cyc_next     = '0;
                st_next      = udps_pkg::ST_DONE;
                entered_next = evt.now_ms;
                act          = rflag ? udps_pkg::ACT_REBOOT : udps_pkg::ACT_NONE;
            end
            else if (st_reg != udps_pkg::ST_DONE)
            begin
                st_next      = udps_pkg::ST_IDLE;
                entered_next = evt.now_ms;
            end
        end
        else if (evt.cmd == udps_pkg::EV_LINK_UP_OTHER)
        begin
            link_next    = 1'b1;
            st_next      = udps_pkg::ST_FOREIGN;
            entered_next = evt.now_ms;
        end
        else if (evt.cmd == udps_pkg::EV_LINK_UP)
        begin
            link_next    = 1'b1;
            cut_next     = '0;
            reboot_next  = 1'b0;
            st_next      = udps_pkg::ST_IDENTIFY;
            entered_next = evt.now_ms;
            act          = udps_pkg::ACT_GET_INFO;
        end
        else if (is_repair)
        begin
            do_rec = 1'b1;
        end
        else
        begin
            unique case (st_reg)
                udps_pkg::ST_IDENTIFY:
                begin
                    if (evt.cmd == udps_pkg::EV_OK)
                    begin
                        entered_next = evt.now_ms;
                        if (cfg.share_mode)
                        begin
                            st_next = udps_pkg::ST_SHARE;
                            act     = udps_pkg::ACT_ENSURE_SHARE;
                        end
                        else
                        begin
                            st_next = udps_pkg::ST_READ_KEY;
                            act     = udps_pkg::ACT_GET_KEY;
                        end
                    end
                    else if (evt.cmd == udps_pkg::EV_NOT_DONGLE)
                    begin
                        st_next      = udps_pkg::ST_FOREIGN;
                        entered_next = evt.now_ms;
                    end
                    else if (evt.cmd == udps_pkg::EV_TICK || evt.cmd == udps_pkg::EV_FAIL)
                    begin
                        if (t_in_state >= {10'd0, cfg.identify_to})
                        begin
                            st_next      = udps_pkg::ST_FOREIGN;
                            entered_next = evt.now_ms;
                        end
                        else if (evt.cmd == udps_pkg::EV_TICK)
                            act = udps_pkg::ACT_GET_INFO;
                    end
                end
                udps_pkg::ST_READ_KEY:
                begin
                    if (evt.cmd == udps_pkg::EV_OK)
                    begin
                        st_next      = udps_pkg::ST_CUT;
                        entered_next = evt.now_ms;
                        cut_next     = udps_pkg::CNT_W'(1);
                        act          = udps_pkg::ACT_POST_CUT;
                    end
                    else if (evt.cmd == udps_pkg::EV_TICK || evt.cmd == udps_pkg::EV_FAIL)
                    begin
                        if (t_in_state >= {10'd0, cfg.key_read_to})
                            do_rec = 1'b1;
                        else if (evt.cmd == udps_pkg::EV_TICK)
                            act = udps_pkg::ACT_GET_KEY;
                    end
                end
                udps_pkg::ST_CUT:
                begin
                    if (evt.cmd == udps_pkg::EV_OK)
                    begin
                        st_next      = udps_pkg::ST_WAIT_DROP;
                        entered_next = evt.now_ms;
                    end
                    else if (evt.cmd == udps_pkg::EV_CONFLICT)
                    begin
                        st_next      = udps_pkg::ST_TETHER;
                        entered_next = evt.now_ms;
                    end
                    else if (evt.cmd == udps_pkg::EV_TICK)
                    begin
                        if (cut_reg >= cfg.retry_lim)
                            do_rec = 1'b1;
                        else
                        begin
                            cut_next = cut_reg + udps_pkg::CNT_W'(1);
                            act      = udps_pkg::ACT_POST_CUT;
                        end
                    end
                end
                udps_pkg::ST_WAIT_DROP:
                begin
                    if (evt.cmd == udps_pkg::EV_TICK)
                    begin
                        if (t_in_state >= {10'd0, cfg.drop_fail})
                            do_rec = 1'b1;
                        else if (t_in_state >= {10'd0, cfg.drop_retry} &&
                                 cut_reg <= cfg.retry_lim)
                        begin
                            cut_next = cfg.retry_lim + udps_pkg::CNT_W'(1);
                            act      = udps_pkg::ACT_POST_CUT;
                        end
                    end
                    else if (evt.cmd == udps_pkg::EV_CONFLICT)
                    begin
                        st_next      = udps_pkg::ST_TETHER;
                        entered_next = evt.now_ms;
                    end
                end
                udps_pkg::ST_DONE:
                begin
                    if (evt.cmd == udps_pkg::EV_AP_STALE)
                        do_rec = 1'b1;
                end
                udps_pkg::ST_SHARE:
                begin
                    if (evt.cmd == udps_pkg::EV_OK)
                    begin
                        cyc_next     = '0;
                        st_next      = udps_pkg::ST_SHARE_UP;
                        entered_next = evt.now_ms;
                    end
                    else if (evt.cmd == udps_pkg::EV_TICK || evt.cmd == udps_pkg::EV_FAIL)
                    begin
                        if (t_in_state >= {10'd0, cfg.share_to})
                        begin
                            st_next      = udps_pkg::ST_SHARE_UP;
                            entered_next = evt.now_ms;
                        end
                        else if (evt.cmd == udps_pkg::EV_TICK)
                            act = udps_pkg::ACT_ENSURE_SHARE;
                    end
                end
                default:
                begin
                    act = udps_pkg::ACT_NONE;
                end
            endcase
        end

        // recovery: power cycle within budget and spacing, else give up
        if (do_rec)
        begin
            entered_next = evt.now_ms;
            if (rec_give)
            begin
                st_next = udps_pkg::ST_FOREIGN;
                act     = udps_pkg::ACT_GIVE_UP;
            end
            else
            begin
                cyc_next     = rec_cyc + udps_pkg::CNT_W'(1);
                last_at_next = evt.now_ms;
                known_next   = 1'b1;
                cut_next     = '0;
                st_next      = udps_pkg::ST_IDLE;
                act          = udps_pkg::ACT_POWER_CYCLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= udps_pkg::ST_IDLE;
            entered_reg <= '0;
            last_at_reg <= '0;
            known_reg   <= 1'b0;
            cyc_reg     <= '0;
            cut_reg     <= '0;
            link_reg    <= 1'b0;
            reboot_reg  <= 1'b0;
        end
        else if (step)
        begin
            st_reg      <= st_next;
            entered_reg <= entered_next;
            last_at_reg <= last_at_next;
            known_reg   <= known_next;
            cyc_reg     <= cyc_next;
            cut_reg     <= cut_next;
            link_reg    <= link_next;
            reboot_reg  <= reboot_next;
        end
    end

    assign res.action     = act;
    assign res.state_code = st_next;
    assign res.link_is_up = link_next;

    // power cycle budget is never overrun
    a_cyc_budget: assert property (@(posedge clk) disable iff (!rst_n)
        cyc_reg <= MAX_CYC)
        else $error("cycle count above budget");

    // link up always restarts identification
    a_link_up_ident: assert property (@(posedge clk) disable iff (!rst_n)
        step && evt.cmd == udps_pkg::EV_LINK_UP |=>
            st_reg == udps_pkg::ST_IDENTIFY && link_reg && !reboot_reg)
        else $error("link up did not enter identify");

endmodule

// File: design/usb_dongle_pairing_sequencer_top.sv
// Path: an accepted event beat goes into the event register, then its result
//   beat into the result register; a stalled result sink holds the event back.
// Throughput: one event per cycle while results are taken; the state update
//   is one subtract/compare pass between the event and result registers.
// Reset (rst_n, async low): machine idle, time base and counters zero, config
//   registers at their defaults; the block is ready right after reset.
// ----------------------------------------------------------------------------
// usb_dongle_pairing_sequencer_top - USB dongle pairing sequencer
// Takes pairing events (code, ms time, reboot mark) and answers each with an
// action, the new state code and the link flag.
// ----------------------------------------------------------------------------
module usb_dongle_pairing_sequencer_top #(
    parameter int unsigned MAX_RECOVERY_CYCLES = udps_pkg::MAX_RECOVERY_CYCLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    udps_evt_if.sink                            evt,
    udps_res_if.source                          res,
    input  logic                                cfg_we,
    input  logic [udps_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [udps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Register file. Writes land directly; the user makes them only while idle, the block does not enforce it.
    udps_pkg::udps_cfg_t cfg;

    udps_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .idx   (cfg_idx),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    // Event register: holds one accepted beat until the state machine
    // consumes it. It refills in the same cycle it drains, so a full
    // result register only stalls the input once both stages are occupied.
    logic                 evt_vld_reg, evt_vld_next;
    udps_pkg::udps_evt_t  evt_reg;
    logic                 evt_take;

    // Result register: decouples the result sink from the state machine.
    logic                 res_vld_reg, res_vld_next;
    udps_pkg::udps_res_t  res_reg;
    udps_pkg::udps_res_t  res_comb;

    // step: the held event is applied to the machine state this cycle
    logic                 step;

    assign step      = evt_vld_reg && (!res_vld_reg || res.ready);
    assign evt.ready = !evt_vld_reg || step;
    assign evt_take  = evt.valid && evt.ready;

    assign evt_vld_next = evt_take || (evt_vld_reg && !step);
    assign res_vld_next = step || (res_vld_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            evt_vld_reg <= evt_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            evt_reg.cmd                <= evt.cmd;
            evt_reg.now_ms             <= evt.now_ms;
            evt_reg.set_reboot_pending <= evt.set_reboot_pending;
        end
        if (step)
        begin
            res_reg <= res_comb;
        end
    end

    // Single-pass state machine: elapsed-time compares, recovery budget
    // check and the next state are all worked out combinationally.
    udps_fsm #(
        .MAX_RECOVERY_CYCLES (MAX_RECOVERY_CYCLES)
    ) u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .evt   (evt_reg),
        .cfg   (cfg),
        .res   (res_comb)
    );

    assign res.valid      = res_vld_reg;
    assign res.action     = res_reg.action;
    assign res.state_code = res_reg.state_code;
    assign res.link_is_up = res_reg.link_is_up;

    // a held event is never dropped while the result side is stalled
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_vld_reg && res_vld_reg && !res.ready |=> evt_vld_reg)
        else $error("held event lost under stall");

    // a power cycle always lands in idle
    a_pc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.action == udps_pkg::ACT_POWER_CYCLE |->
            res.state_code == udps_pkg::ST_IDLE)
        else $error("power cycle without idle state");

    // giving up always lands in foreign
    a_giveup_foreign: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.action == udps_pkg::ACT_GIVE_UP |->
            res.state_code == udps_pkg::ST_FOREIGN)
        else $error("give up without foreign state");

endmodule
